// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define ASSERT_HOLDS(lbl, clk_sig, rst_sig, cond)
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons)

`endif

`endif

// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 7;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_HEAD   = 3'd1,
    ACT_TAIL   = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_DELETE = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       element_count;
  } out_item_t;

  typedef struct packed {
    cell_op_t op;
    status_t  status;
    logic     is_read;
    logic     read_hit;
  } ctrl_t;

endpackage

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list element: holds, loads, or takes the value of a neighbor.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
#(
  parameter int CMPW  = 8,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic [CMPW-1:0]          pos,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] read_value
);

  localparam logic [CMPW-1:0] MY_INDEX = CMPW'(INDEX);

  logic signed [DATA_W-1:0] value_next;
  logic                     here;
  logic                     after;

  assign here  = (pos == MY_INDEX);
  assign after = (MY_INDEX > pos);

  always_comb begin
    value_next = value;
    case (op)
      CELL_INSERT: begin
        if (here) begin
          value_next = ins_value;
        end else if (after) begin
          value_next = left_value;
        end
      end
      CELL_DELETE: begin
        if (here || after) begin
          value_next = right_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign read_value = here ? value : '0;

endmodule

// ===== rtl/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl
// Decodes an action against the count into a cell command and a status.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int CNTW     = 7,
  parameter int CMPW     = 8
) (
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]    position,
  input  logic [CNTW-1:0]     count,
  output ctrl_t               ctrl,
  output logic [CMPW-1:0]     cmd_pos,
  output logic [CNTW-1:0]     count_next
);

  localparam logic [CNTW-1:0] CAP = CNTW'(CAPACITY);

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] ins_pos;
  logic            is_insert;

  assign pos_ext = CMPW'(position);
  assign cnt_ext = CMPW'(count);

  always_comb begin
    ins_pos   = pos_ext;
    is_insert = 1'b0;
    case (action)
      ACT_HEAD: begin
        ins_pos   = '0;
        is_insert = 1'b1;
      end
      ACT_TAIL: begin
        ins_pos   = cnt_ext;
        is_insert = 1'b1;
      end
      ACT_INSERT: begin
        is_insert = 1'b1;
      end
      default: begin
        ins_pos   = pos_ext;
        is_insert = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.status   = ST_DONE;
    ctrl.is_read  = 1'b0;
    ctrl.read_hit = 1'b0;
    cmd_pos       = pos_ext;
    count_next    = count;
    if (is_insert) begin
      cmd_pos = ins_pos;
      if (ins_pos > cnt_ext) begin
        ctrl.status = ST_RANGE;
      end else if (count == CAP) begin
        ctrl.status = ST_FULL;
      end else begin
        ctrl.op    = CELL_INSERT;
        count_next = count + CNTW'(1);
      end
    end else begin
      case (action)
        ACT_READ: begin
          ctrl.is_read = 1'b1;
          if (pos_ext < cnt_ext) begin
            ctrl.read_hit = 1'b1;
          end else begin
            ctrl.status = ST_RANGE;
          end
        end
        ACT_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            ctrl.status = ST_RANGE;
          end else begin
            ctrl.op    = CELL_DELETE;
            count_next = count - CNTW'(1);
          end
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/indexed_list_store_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed words held in a row of cells, with indexed read,
// insert and delete.
//
//   channel  | payload     | handshake
//   ---------+-------------+----------------------
//   in       | in_item_t   | in_valid / in_ready
//   out      | out_item_t  | out_valid / out_ready
//
// One transaction per cycle; its result appears in the output register the
// cycle after acceptance. Every cell shifts, loads or holds in that same
// cycle, so no action takes longer. in_ready drops only while a result waits
// in the output register. Reset clears the count and output valid; cell
// contents are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_store_core
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  logic [CNTW-1:0]          count;
  logic [CNTW-1:0]          count_next;
  ctrl_t                    ctrl;
  logic [CMPW-1:0]          cmd_pos;
  logic                     in_accept;
  cell_op_t                 cell_op;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic signed [DATA_W-1:0] cell_read  [CAPACITY];
  logic signed [DATA_W-1:0] read_sel;
  logic signed [DATA_W-1:0] read_word;
  logic                     full_count_ok;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cell_op   = in_accept ? ctrl.op : CELL_HOLD;

  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .CNTW     (CNTW),
    .CMPW     (CMPW)
  ) u_ctrl (
    .action     (in_data.action),
    .position   (in_data.position),
    .count      (count),
    .ctrl       (ctrl),
    .cmd_pos    (cmd_pos),
    .count_next (count_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = in_data.item_value;
    end else begin : g_left
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_right
      assign right_value = cell_value[i+1];
    end

    ils_cell #(
      .CMPW  (CMPW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .pos         (cmd_pos),
      .ins_value   (in_data.item_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .read_value  (cell_read[i])
    );
  end

  always_comb begin
    read_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_sel = read_sel | cell_read[i];
    end
  end

  always_comb begin
    read_word = '0;
    if (ctrl.is_read) begin
      read_word = ctrl.read_hit ? read_sel : -32'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.read_value    <= read_word;
      out_data.status        <= ctrl.status;
      out_data.element_count <= COUNT_W'(count_next);
    end
  end

  assign full_count_ok = !(out_valid && out_data.status == ST_FULL) ||
                         (out_data.element_count == COUNT_W'(CAPACITY));

  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNTW'(CAPACITY))
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, in_accept, out_valid)
  `ASSERT_NEXT(a_count_stable_idle, clk, rst, !in_accept, $stable(count))
  `ASSERT_HOLDS(a_full_at_capacity, clk, rst, full_count_ok)

endmodule
